// ===== sv/srt_pkg.sv =====
package srt_pkg;

  // Default sizes handed to the top level
  localparam int DEF_PENDING_DEPTH = 16;
  localparam int DEF_HANDLE_BITS   = 10;

  // Fixed field widths
  localparam int SEQ_W   = 32;
  localparam int LEN_W   = 16;
  localparam int TOTAL_W = 21;
  localparam int MOD_W   = 33;
  localparam int CFG_W   = 33;
  localparam int CFG_IDX_W = 1;

  // Depth of the ingress and egress queues
  localparam int QUEUE_DEPTH = 2;

  // Full sequence space, also the modulus after reset
  localparam logic [MOD_W-1:0] SEQ_SPACE = {1'b1, {(MOD_W-1){1'b0}}};

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_EXPECTED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_MODULUS      = 1'b1;

  typedef enum logic [1:0] {
    OUT_DELIVERED  = 2'd0,
    OUT_BUFFERED   = 2'd1,
    OUT_DUPLICATE  = 2'd2,
    OUT_TABLE_FULL = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    S_CLASSIFY,
    S_ADVANCE,
    S_DIVIDE,
    S_EMIT
  } engine_state_t;

  // Effective modulus: zero and anything above the full space mean the full space
  function automatic logic [MOD_W-1:0] effective_modulus(input logic [CFG_W-1:0] raw);
    logic [MOD_W-1:0] m;
    m = raw[MOD_W-1:0];
    if (m == '0 || (m[MOD_W-1] && m[MOD_W-2:0] != '0)) begin
      m = SEQ_SPACE;
    end
    return m;
  endfunction

endpackage

// ===== sv/srt_fifo.sv =====
module srt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = srt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== sv/srt_engine.sv =====
module srt_engine #(
  parameter int PENDING_DEPTH = srt_pkg::DEF_PENDING_DEPTH,
  parameter int HANDLE_BITS   = srt_pkg::DEF_HANDLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic [srt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srt_pkg::CFG_W-1:0]        cfg_data,
  // head of the ingress queue
  input  logic                             in_valid,
  input  logic [srt_pkg::SEQ_W-1:0]        in_seq,
  input  logic [srt_pkg::LEN_W-1:0]        in_len,
  input  logic [HANDLE_BITS-1:0]           in_handle,
  output logic                             in_take,
  // egress queue
  input  logic                             out_space,
  output logic                             out_push,
  output srt_pkg::outcome_t                res_outcome,
  output logic [srt_pkg::SEQ_W-1:0]        res_seq,
  output logic [srt_pkg::LEN_W-1:0]        res_len,
  output logic [HANDLE_BITS-1:0]           res_handle,
  output logic [srt_pkg::TOTAL_W-1:0]      res_bytes,
  output logic [srt_pkg::SEQ_W-1:0]        res_next_expected,
  output logic                             res_last
);

  localparam int SEQ_W   = srt_pkg::SEQ_W;
  localparam int LEN_W   = srt_pkg::LEN_W;
  localparam int TOTAL_W = srt_pkg::TOTAL_W;
  localparam int MOD_W   = srt_pkg::MOD_W;
  localparam int IDX_W   = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int BIT_W   = $clog2(MOD_W);

  srt_pkg::engine_state_t state;
  srt_pkg::engine_state_t state_next;

  // Configuration and running state
  logic [SEQ_W-1:0] expected;
  logic [MOD_W-1:0] modulus;

  // Pending table
  logic [PENDING_DEPTH-1:0] pv;
  logic [SEQ_W-1:0]         pseq  [PENDING_DEPTH];
  logic [LEN_W-1:0]         plen  [PENDING_DEPTH];
  logic [HANDLE_BITS-1:0]   phand [PENDING_DEPTH];

  // Segment being released
  logic [SEQ_W-1:0]       cur_seq;
  logic [LEN_W-1:0]       cur_len;
  logic [HANDLE_BITS-1:0] cur_handle;
  logic [TOTAL_W-1:0]     total;

  // Advance unit: sum and remainder of the serial reduction
  logic [MOD_W-1:0] sum;
  logic [MOD_W-1:0] rem;
  logic [BIT_W-1:0] bit_idx;

  logic [PENDING_DEPTH-1:0] hit_vec;
  logic [PENDING_DEPTH-1:0] dup_vec;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         free_idx;
  logic                     any_hit;
  logic                     any_dup;
  logic                     any_free;
  logic                     in_match;
  logic [MOD_W-1:0]         sum_less_mod;
  logic [MOD_W:0]           div_trial;
  logic [MOD_W:0]           div_diff;
  logic                     div_ge;
  logic [MOD_W-1:0]         div_next;
  logic                     table_write;

  // Parallel match against the table
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
      hit_vec[i] = pv[i] && (pseq[i] == expected);
      dup_vec[i] = pv[i] && (pseq[i] == in_seq);
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!pv[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit  = |hit_vec;
  assign any_dup  = |dup_vec;
  assign any_free = ~&pv;
  assign in_match = (in_seq == expected);

  // One remainder step per cycle
  assign sum_less_mod = sum - modulus;
  assign div_trial    = {rem, sum[bit_idx]};
  assign div_ge       = (div_trial >= {1'b0, modulus});
  assign div_diff     = div_trial - {1'b0, modulus};
  assign div_next     = div_ge ? div_diff[MOD_W-1:0] : div_trial[MOD_W-1:0];

  // Next state and result
  always_comb begin
    state_next        = state;
    in_take           = 1'b0;
    out_push          = 1'b0;
    table_write       = 1'b0;
    res_outcome       = srt_pkg::OUT_DELIVERED;
    res_seq           = cur_seq;
    res_len           = cur_len;
    res_handle        = cur_handle;
    res_bytes         = total;
    res_next_expected = expected;
    res_last          = 1'b1;
    case (state)
      srt_pkg::S_CLASSIFY: begin
        res_seq    = in_seq;
        res_len    = in_len;
        res_handle = in_handle;
        res_bytes  = '0;
        if (any_dup) begin
          res_outcome = srt_pkg::OUT_DUPLICATE;
        end else if (!any_free) begin
          res_outcome = srt_pkg::OUT_TABLE_FULL;
        end else begin
          res_outcome = srt_pkg::OUT_BUFFERED;
        end
        if (in_valid && in_match) begin
          in_take    = 1'b1;
          state_next = srt_pkg::S_ADVANCE;
        end else if (in_valid && out_space) begin
          in_take     = 1'b1;
          out_push    = 1'b1;
          table_write = !any_dup && any_free;
        end
      end
      srt_pkg::S_ADVANCE: begin
        if (sum < modulus || sum_less_mod < modulus) begin
          state_next = srt_pkg::S_EMIT;
        end else begin
          state_next = srt_pkg::S_DIVIDE;
        end
      end
      srt_pkg::S_DIVIDE: begin
        if (bit_idx == '0) begin
          state_next = srt_pkg::S_EMIT;
        end
      end
      srt_pkg::S_EMIT: begin
        res_last = !any_hit;
        if (out_space) begin
          out_push   = 1'b1;
          state_next = any_hit ? srt_pkg::S_ADVANCE : srt_pkg::S_CLASSIFY;
        end
      end
      default: begin
        state_next = srt_pkg::S_CLASSIFY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srt_pkg::S_CLASSIFY;
    end else begin
      state <= state_next;
    end
  end

  // Expectation, modulus and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      expected <= '0;
      modulus  <= srt_pkg::SEQ_SPACE;
      pv       <= '0;
    end else begin
      case (state)
        srt_pkg::S_CLASSIFY: begin
          if (table_write) begin
            pv[free_idx] <= 1'b1;
          end
        end
        srt_pkg::S_ADVANCE: begin
          if (sum < modulus) begin
            expected <= sum[SEQ_W-1:0];
          end else if (sum_less_mod < modulus) begin
            expected <= sum_less_mod[SEQ_W-1:0];
          end
        end
        srt_pkg::S_DIVIDE: begin
          if (bit_idx == '0) begin
            expected <= div_next[SEQ_W-1:0];
          end
        end
        srt_pkg::S_EMIT: begin
          if (out_space && any_hit) begin
            pv[hit_idx] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (cfg_write && cfg_index == srt_pkg::REG_INITIAL_EXPECTED) begin
        expected <= cfg_data[SEQ_W-1:0];
      end
      if (cfg_write && cfg_index == srt_pkg::REG_SEQ_MODULUS) begin
        modulus <= srt_pkg::effective_modulus(cfg_data);
      end
    end
  end

  // Table contents and working registers
  always_ff @(posedge clk) begin
    case (state)
      srt_pkg::S_CLASSIFY: begin
        if (table_write) begin
          pseq[free_idx]  <= in_seq;
          plen[free_idx]  <= in_len;
          phand[free_idx] <= in_handle;
        end
        if (in_valid && in_match) begin
          cur_seq    <= in_seq;
          cur_len    <= in_len;
          cur_handle <= in_handle;
          total      <= TOTAL_W'(in_len);
          sum        <= {1'b0, expected} + MOD_W'(in_len);
        end
      end
      srt_pkg::S_ADVANCE: begin
        rem     <= '0;
        bit_idx <= BIT_W'(MOD_W - 1);
      end
      srt_pkg::S_DIVIDE: begin
        rem     <= div_next;
        bit_idx <= bit_idx - 1'b1;
      end
      srt_pkg::S_EMIT: begin
        if (out_space && any_hit) begin
          cur_seq    <= pseq[hit_idx];
          cur_len    <= plen[hit_idx];
          cur_handle <= phand[hit_idx];
          total      <= total + TOTAL_W'(plen[hit_idx]);
          sum        <= {1'b0, expected} + MOD_W'(plen[hit_idx]);
        end
      end
      default: begin
      end
    endcase
  end

  // Stored sequence numbers stay unique, so at most one entry matches
  assert property (@(posedge clk) disable iff (rst) $countones(hit_vec) <= 1)
    else $error("more than one pending entry matches the expectation");

  // The serial reduction keeps its remainder below the modulus
  assert property (@(posedge clk) disable iff (rst)
    state == srt_pkg::S_DIVIDE |-> rem < modulus)
    else $error("remainder not reduced below modulus");

  // A released segment always reports a reduced expectation
  assert property (@(posedge clk) disable iff (rst)
    state == srt_pkg::S_EMIT |-> {1'b0, expected} < modulus)
    else $error("expectation beyond modulus after advance");

  // Results only go out when the egress queue has room
  assert property (@(posedge clk) disable iff (rst) out_push |-> out_space)
    else $error("result pushed into a full queue");

  // A table write only happens into a slot that was free
  assert property (@(posedge clk) disable iff (rst)
    table_write |=> pv[$past(free_idx)] && $countones(pv) == $countones($past(pv)) + 1)
    else $error("table insert did not claim exactly one free slot");

endmodule

// ===== sv/segment_reassembly_tracker.sv =====
// Segment reassembly tracker. Each arriving segment descriptor (sequence number, length,
// buffer handle) is pushed into a short ingress queue; results are popped from an egress
// queue, one or more per segment, the final one marked by last_of_run. A segment that is
// not the expected one is buffered in the pending table or dropped. An expected segment
// goes through classify, advance and emit, each entry released behind it through advance
// and emit; an advance whose sum reaches twice the modulus also runs the bit-serial
// remainder unit, which only happens with a modulus below 2^16 or after the expectation
// has been loaded beyond the modulus. The pending table needs no clearing pass after
// reset. Configuration writes must only be made while the block is idle.
module segment_reassembly_tracker #(
  parameter int PENDING_DEPTH = srt_pkg::DEF_PENDING_DEPTH,
  parameter int HANDLE_BITS   = srt_pkg::DEF_HANDLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [srt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srt_pkg::CFG_W-1:0]         cfg_data,
  // segment input
  input  logic                              push,
  output logic                              full,
  input  logic [srt_pkg::SEQ_W-1:0]         seq_number,
  input  logic [srt_pkg::LEN_W-1:0]         seg_length,
  input  logic [HANDLE_BITS-1:0]            buffer_handle,
  // results
  input  logic                              pop,
  output logic                              empty,
  output logic [1:0]                        outcome,
  output logic [srt_pkg::SEQ_W-1:0]         out_seq,
  output logic [srt_pkg::LEN_W-1:0]         out_length,
  output logic [HANDLE_BITS-1:0]            out_handle,
  output logic [srt_pkg::TOTAL_W-1:0]       bytes_released,
  output logic [srt_pkg::SEQ_W-1:0]         next_expected,
  output logic                              last_of_run
);

  localparam int IN_W  = srt_pkg::SEQ_W + srt_pkg::LEN_W + HANDLE_BITS;
  localparam int OUT_W = 2 + srt_pkg::SEQ_W + srt_pkg::LEN_W + HANDLE_BITS
                       + srt_pkg::TOTAL_W + srt_pkg::SEQ_W + 1;

  logic [IN_W-1:0]  in_head;
  logic             in_empty;
  logic             in_take;

  logic [srt_pkg::SEQ_W-1:0] head_seq;
  logic [srt_pkg::LEN_W-1:0] head_len;
  logic [HANDLE_BITS-1:0]    head_handle;

  logic                        out_full;
  logic                        out_push;
  srt_pkg::outcome_t           res_outcome;
  logic [srt_pkg::SEQ_W-1:0]   res_seq;
  logic [srt_pkg::LEN_W-1:0]   res_len;
  logic [HANDLE_BITS-1:0]      res_handle;
  logic [srt_pkg::TOTAL_W-1:0] res_bytes;
  logic [srt_pkg::SEQ_W-1:0]   res_next_expected;
  logic                        res_last;
  logic [OUT_W-1:0]            res_word;
  logic [OUT_W-1:0]            out_word;

  // Ingress queue: takes segments while the engine is busy
  srt_fifo #(
    .WIDTH (IN_W),
    .DEPTH (srt_pkg::QUEUE_DEPTH)
  ) u_ingress (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({seq_number, seg_length, buffer_handle}),
    .full  (full),
    .pop   (in_take),
    .rdata (in_head),
    .empty (in_empty)
  );

  assign {head_seq, head_len, head_handle} = in_head;

  // Classification, pending table and release sequencer
  srt_engine #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .HANDLE_BITS   (HANDLE_BITS)
  ) u_engine (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (!in_empty),
    .in_seq            (head_seq),
    .in_len            (head_len),
    .in_handle         (head_handle),
    .in_take           (in_take),
    .out_space         (!out_full),
    .out_push          (out_push),
    .res_outcome       (res_outcome),
    .res_seq           (res_seq),
    .res_len           (res_len),
    .res_handle        (res_handle),
    .res_bytes         (res_bytes),
    .res_next_expected (res_next_expected),
    .res_last          (res_last)
  );

  assign res_word = {res_outcome, res_seq, res_len, res_handle, res_bytes,
                     res_next_expected, res_last};

  // Egress queue: results wait here until popped
  srt_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (srt_pkg::QUEUE_DEPTH)
  ) u_egress (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (res_word),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_word),
    .empty (empty)
  );

  assign {outcome, out_seq, out_length, out_handle, bytes_released, next_expected,
          last_of_run} = out_word;

endmodule

// ===== test/segment_reassembly_tracker_tb.sv =====
`timescale 1ns / 1ps

module segment_reassembly_tracker_tb;

  localparam int DEPTH     = srt_pkg::DEF_PENDING_DEPTH;
  localparam int HANDLE_W  = srt_pkg::DEF_HANDLE_BITS;
  localparam int SEQ_W     = srt_pkg::SEQ_W;
  localparam int LEN_W     = srt_pkg::LEN_W;
  localparam int TOTAL_W   = srt_pkg::TOTAL_W;
  localparam int MOD_W     = srt_pkg::MOD_W;
  localparam int CFG_W     = srt_pkg::CFG_W;
  localparam int CFG_IDX_W = srt_pkg::CFG_IDX_W;

  // One result as the block should present it
  typedef struct {
    srt_pkg::outcome_t     outcome;
    logic [SEQ_W-1:0]      seq;
    logic [LEN_W-1:0]      len;
    logic [HANDLE_W-1:0]   handle;
    logic [TOTAL_W-1:0]    released;
    logic [SEQ_W-1:0]      next_exp;
    logic                  ends_run;
  } seg_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = srt_pkg::REG_INITIAL_EXPECTED;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [SEQ_W-1:0]      seq_number = '0;
  logic [LEN_W-1:0]      seg_length = '0;
  logic [HANDLE_W-1:0]   buffer_handle = '0;
  logic                  pop = 1'b0;
  logic                  empty;
  logic [1:0]            outcome;
  logic [SEQ_W-1:0]      out_seq;
  logic [LEN_W-1:0]      out_length;
  logic [HANDLE_W-1:0]   out_handle;
  logic [TOTAL_W-1:0]    bytes_released;
  logic [SEQ_W-1:0]      next_expected;
  logic                  last_of_run;

  // Idling rates, in percent
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  // Shadow of the tracker: registers, expectation and pending table
  logic [SEQ_W-1:0]      model_expected = '0;
  logic [MOD_W-1:0]      model_modulus  = srt_pkg::SEQ_SPACE;
  logic                  held_valid [DEPTH];
  logic [SEQ_W-1:0]      held_seq   [DEPTH];
  logic [LEN_W-1:0]      held_len   [DEPTH];
  logic [HANDLE_W-1:0]   held_handle[DEPTH];

  seg_result_t results_due[$];

  int mismatches = 0;
  int n_arrivals = 0;
  int n_delivered = 0;
  int n_buffered = 0;
  int n_duplicate = 0;
  int n_full = 0;
  int n_writes = 0;

  segment_reassembly_tracker u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .seq_number    (seq_number),
    .seg_length    (seg_length),
    .buffer_handle (buffer_handle),
    .pop           (pop),
    .empty         (empty),
    .outcome       (outcome),
    .out_seq       (out_seq),
    .out_length    (out_length),
    .out_handle    (out_handle),
    .bytes_released(bytes_released),
    .next_expected (next_expected),
    .last_of_run   (last_of_run)
  );

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      held_valid[i] = 1'b0;
    end
  end

  // Expectation advance, wrapping at the effective modulus
  function automatic logic [SEQ_W-1:0] advance_seq(input logic [SEQ_W-1:0] cur,
                                                   input logic [LEN_W-1:0] len);
    logic [63:0] m;
    logic [63:0] sum;
    m = {31'b0, model_modulus};
    if (m == 64'd0 || m > 64'h1_0000_0000) begin
      m = 64'h1_0000_0000;
    end
    sum = ({32'b0, cur} + {48'b0, len}) % m;
    return sum[SEQ_W-1:0];
  endfunction

  function automatic seg_result_t make_result(input srt_pkg::outcome_t oc,
                                              input logic [SEQ_W-1:0] seq,
                                              input logic [LEN_W-1:0] len,
                                              input logic [HANDLE_W-1:0] handle,
                                              input logic [TOTAL_W-1:0] released);
    seg_result_t r;
    r.outcome  = oc;
    r.seq      = seq;
    r.len      = len;
    r.handle   = handle;
    r.released = released;
    r.next_exp = model_expected;
    r.ends_run = 1'b0;
    return r;
  endfunction

  // Works out the results of one arrival and updates the shadow state
  task automatic predict_release(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                                 input logic [HANDLE_W-1:0] handle);
    seg_result_t run[$];
    logic [TOTAL_W-1:0] total;
    int hit;
    int free_slot;
    logic dup;
    int i;
    n_arrivals++;
    if (seq == model_expected) begin
      total = TOTAL_W'(len);
      model_expected = advance_seq(model_expected, len);
      run.push_back(make_result(srt_pkg::OUT_DELIVERED, seq, len, handle, total));
      n_delivered++;
      // pull held segments for as long as one matches the new expectation
      do begin
        hit = -1;
        for (i = 0; i < DEPTH; i++) begin
          if (hit < 0 && held_valid[i] && held_seq[i] == model_expected) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          held_valid[hit] = 1'b0;
          total = total + TOTAL_W'(held_len[hit]);
          model_expected = advance_seq(model_expected, held_len[hit]);
          run.push_back(make_result(srt_pkg::OUT_DELIVERED, held_seq[hit], held_len[hit],
                                    held_handle[hit], total));
          n_delivered++;
        end
      end while (hit >= 0);
    end else begin
      free_slot = -1;
      dup = 1'b0;
      for (i = 0; i < DEPTH; i++) begin
        if (held_valid[i]) begin
          if (held_seq[i] == seq) dup = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      // duplicate is reported even when the table is also full
      if (dup) begin
        run.push_back(make_result(srt_pkg::OUT_DUPLICATE, seq, len, handle, '0));
        n_duplicate++;
      end else if (free_slot < 0) begin
        run.push_back(make_result(srt_pkg::OUT_TABLE_FULL, seq, len, handle, '0));
        n_full++;
      end else begin
        held_valid[free_slot]  = 1'b1;
        held_seq[free_slot]    = seq;
        held_len[free_slot]    = len;
        held_handle[free_slot] = handle;
        run.push_back(make_result(srt_pkg::OUT_BUFFERED, seq, len, handle, '0));
        n_buffered++;
      end
    end
    run[run.size()-1].ends_run = 1'b1;
    foreach (run[k]) results_due.push_back(run[k]);
  endtask

  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: check each transfer, then decide whether to stall
  always @(posedge clk) begin
    seg_result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual outcome %0d seq %h",
                   $time, outcome, out_seq);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          compare_field("outcome", want.outcome, outcome);
          compare_field("out_seq", want.seq, out_seq);
          compare_field("out_length", want.len, out_length);
          compare_field("out_handle", want.handle, out_handle);
          compare_field("bytes_released", want.released, bytes_released);
          compare_field("next_expected", want.next_exp, next_expected);
          compare_field("last_of_run", want.ends_run, last_of_run);
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // One segment transfer; push stays high on return so back-to-back items need no bubble
  task automatic send_segment(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                              input logic [HANDLE_W-1:0] handle);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    seq_number    <= seq;
    seg_length    <= len;
    buffer_handle <= handle;
    do @(posedge clk); while (full);
    predict_release(seq, len, handle);
  endtask

  // Drop push and wait for every outstanding result
  task automatic wait_idle();
    push <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
    @(posedge clk);
  endtask

  // Register write; only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    if (index == srt_pkg::REG_INITIAL_EXPECTED) begin
      model_expected = value[SEQ_W-1:0];
    end else begin
      model_modulus = value[MOD_W-1:0];
    end
    n_writes++;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int first_held();
    int slot;
    slot = -1;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (held_valid[i]) slot = i;
    end
    return slot;
  endfunction

  // Empty the pending table: point the expectation at each held segment and send a
  // zero-length segment there, which releases it and anything chained behind it
  task automatic flush_table();
    int slot;
    wait_idle();
    write_reg(srt_pkg::REG_SEQ_MODULUS, srt_pkg::SEQ_SPACE);
    slot = first_held();
    while (slot >= 0) begin
      write_reg(srt_pkg::REG_INITIAL_EXPECTED, {1'b0, held_seq[slot]});
      send_segment(held_seq[slot], '0, HANDLE_W'($urandom));
      wait_idle();
      slot = first_held();
    end
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    logic [LEN_W-1:0] len;
    case ($urandom_range(0, 9))
      0:       len = '0;
      1, 2:    len = LEN_W'($urandom_range(0, 65535));
      default: len = LEN_W'($urandom_range(1, 1500));
    endcase
    return len;
  endfunction

  // Contiguous run from the current expectation, sent in shuffled order; now and then
  // one segment goes missing or is sent twice
  task automatic send_burst(output int sent);
    logic [SEQ_W-1:0] seqs[$];
    logic [LEN_W-1:0] lens[$];
    int order[$];
    logic [SEQ_W-1:0] cursor;
    int n, k, j, tmp, lost, resent;
    cursor = model_expected;
    n = $urandom_range(1, 18);
    for (k = 0; k < n; k++) begin
      lens.push_back(pick_length());
      seqs.push_back(cursor);
      cursor = advance_seq(cursor, lens[k]);
      order.push_back(k);
    end
    for (k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    lost   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
    resent = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
    sent = 0;
    for (k = 0; k < n; k++) begin
      if (order[k] != lost) begin
        send_segment(seqs[order[k]], lens[order[k]], HANDLE_W'($urandom));
        sent++;
        if (order[k] == resent) begin
          send_segment(seqs[order[k]], lens[order[k]], HANDLE_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  // In-order delivery, field extremes, zero length and wrap at the full space
  task automatic test_in_order();
    send_segment(32'd0, 16'd0, '0);
    send_segment(32'd0, 16'hFFFF, '1);
    wait_idle();
    write_reg(srt_pkg::REG_INITIAL_EXPECTED, {1'b0, 32'hFFFF_FFFF});
    send_segment(32'hFFFF_FFFF, 16'd1, HANDLE_W'('h2AA));
  endtask

  // Out-of-order arrivals held, then released in a chain; an old number is held too
  task automatic test_drain_chain();
    send_segment(32'd300, 16'd100, HANDLE_W'(3));
    send_segment(32'd100, 16'd200, HANDLE_W'(2));
    send_segment(32'd0, 16'd100, HANDLE_W'(1));
    send_segment(32'd50, 16'd10, HANDLE_W'(4));
  endtask

  // Duplicate drop, table fill, full drop, and duplicate taking priority over full
  task automatic test_duplicate_and_full();
    send_segment(32'd1000, 16'd5, HANDLE_W'(7));
    send_segment(32'd1000, 16'd9, HANDLE_W'(8));
    for (int k = 0; k < DEPTH - 2; k++) begin
      send_segment(32'd2000 + 32'(k) * 32'd16, LEN_W'(k + 1), HANDLE_W'(k));
    end
    send_segment(32'd5000, 16'd1, HANDLE_W'(9));
    send_segment(32'd1000, 16'd1, HANDLE_W'(1));
    flush_table();
  endtask

  // Modulus of two, modulus of one, zero and oversize modulus, expectation past modulus
  task automatic test_modulus_corners();
    wait_idle();
    write_reg(srt_pkg::REG_SEQ_MODULUS, 33'd2);
    write_reg(srt_pkg::REG_INITIAL_EXPECTED, {1'b0, 32'hFFFF_FFFE});
    send_segment(32'hFFFF_FFFE, 16'd1, HANDLE_W'(5));
    send_segment(32'd1, 16'hFFFF, HANDLE_W'(6));
    wait_idle();
    write_reg(srt_pkg::REG_SEQ_MODULUS, 33'd1);
    write_reg(srt_pkg::REG_INITIAL_EXPECTED, 33'd5);
    send_segment(32'd5, 16'd7, HANDLE_W'(7));
    send_segment(32'd0, 16'd3, HANDLE_W'(8));
    wait_idle();
    write_reg(srt_pkg::REG_SEQ_MODULUS, 33'd0);
    write_reg(srt_pkg::REG_INITIAL_EXPECTED, {1'b0, 32'hFFFF_FFF0});
    send_segment(32'hFFFF_FFF0, 16'h20, HANDLE_W'(9));
    wait_idle();
    write_reg(srt_pkg::REG_SEQ_MODULUS, 33'h1_FFFF_FFFF);
    write_reg(srt_pkg::REG_INITIAL_EXPECTED, {1'b0, 32'hFFFF_FFFF});
    send_segment(32'hFFFF_FFFF, 16'd2, HANDLE_W'(10));
  endtask

  // Mostly contiguous bursts with random content, plus stray and repeated segments,
  // over several register settings
  task automatic test_random_traffic(input int gap_pct, input int stall_pct);
    logic [CFG_W-1:0] modulus;
    logic [SEQ_W-1:0] start;
    logic [SEQ_W-1:0] stray;
    int count, sent, slot;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (int s = 0; s < 4; s++) begin
      case ($urandom_range(0, 6))
        0:       modulus = srt_pkg::SEQ_SPACE;
        1:       modulus = '0;
        2:       modulus = {1'b1, 32'($urandom) | 32'd1};
        3:       modulus = CFG_W'($urandom_range(2, 40));
        4:       modulus = CFG_W'($urandom_range(1000, 200000));
        5:       modulus = 33'h1_FFFF_FFFF;
        default: modulus = {1'b0, 32'($urandom) | 32'd2};
      endcase
      case ($urandom_range(0, 3))
        0:       start = '0;
        1:       start = '1;
        default: start = $urandom;
      endcase
      wait_idle();
      write_reg(srt_pkg::REG_SEQ_MODULUS, modulus);
      write_reg(srt_pkg::REG_INITIAL_EXPECTED, {1'b0, start});
      count = 0;
      while (count < 30) begin
        case ($urandom_range(0, 9))
          7: begin
            // stray number: anywhere, or a little behind the expectation
            stray = ($urandom_range(0, 1) == 0) ? 32'($urandom)
                                                : model_expected - 32'($urandom_range(1, 5000));
            send_segment(stray, pick_length(), HANDLE_W'($urandom));
            count++;
          end
          8: begin
            // repeat of a held number, or a fresh stray if none is held
            slot = first_held();
            stray = (slot >= 0) ? held_seq[slot] : 32'($urandom);
            send_segment(stray, pick_length(), HANDLE_W'($urandom));
            count++;
          end
          default: begin
            send_burst(sent);
            count += sent;
          end
        endcase
      end
      flush_table();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_gap_pct   = 8;
    recv_stall_pct = 74;
    test_in_order();
    test_drain_chain();
    test_duplicate_and_full();
    test_modulus_corners();
    test_random_traffic(8, 74);
    test_random_traffic(74, 8);
    test_random_traffic(0, 0);
    wait_idle();
    // let any stray result surface
    repeat (64) @(posedge clk);
    $display("%0d segments: %0d delivered, %0d buffered, %0d duplicates, %0d table-full drops",
             n_arrivals, n_delivered, n_buffered, n_duplicate, n_full);
    $display("%0d register writes, moduli from 1 to above 2^32, three idling patterns",
             n_writes);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

endmodule
